[design/cpc_pkg.sv]
package cpc_pkg;

    localparam int CPC_MAX_LEN = 256;

    // config register indexes (paddr[2])
    localparam logic CFG_FOLD_CASE  = 1'b0;
    localparam logic CFG_DICT_ORDER = 1'b1;

    typedef enum logic [2:0] {
        ORD_BEFORE = 3'd0,   // key sorts before entry
        ORD_PREFIX = 3'd1,   // key is a proper prefix of entry
        ORD_EQUAL  = 3'd2,
        ORD_SHORT  = 3'd3,   // entry is a proper prefix of key
        ORD_AFTER  = 3'd4
    } ord_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CMP  = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // request handed from the front stage to the compare stage
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;           // canonical entry byte
        logic       len_reached;  // entry position at or past key length
    } item_t;

    typedef struct packed {
        logic       keep;
        logic [7:0] value;
    } canon_t;

    function automatic canon_t cpc_canon(logic [7:0] c, logic fold, logic dict);
        logic   is_upper;
        logic   is_lower;
        logic   is_digit;
        canon_t r;
        is_upper = (c >= 8'h41) && (c <= 8'h5A);
        is_lower = (c >= 8'h61) && (c <= 8'h7A);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        r.keep   = !dict || is_upper || is_lower || is_digit || (c == 8'h20) || (c == 8'h09);
        r.value  = (fold && is_upper) ? (c + 8'h20) : c;
        return r;
    endfunction

endpackage

[design/canonical_prefix_compare_unit.sv]
// Canonical prefix compare unit.
//
// Input stream (s_*): one byte per request. s_tuser = 0 marks a key byte,
// 1 an entry byte; s_tdata carries the raw byte, and a zero byte ends the
// current key or entry. Key bytes are canonicalized and stored; entry
// bytes are compared against the stored key as they arrive.
// Output stream (m_*): one request per entry, issued for its zero byte,
// giving the five-way order code and the prefix-match flag.
// APB port: register 0 (addr 0) fold_case, register 1 (addr 4) dict_order,
// both reset to 1. New values apply from the next accepted byte.
// Throughput: one byte per cycle while s_tready is high. Each kept nonzero
// byte below the length limit costs one access of the key RAM (a write
// for key bytes, a read for entry bytes). A zero byte is registered in
// the compare stage, and its result then in the output register (m_tvalid).
// Reset: clears counters, key length and compare state; the key RAM is not
// cleared, only positions below the key length are ever compared.
// Stall: the compare stage keeps taking bytes while a result waits in the
// output register; s_tready drops only when a second result is ready behind
// an unaccepted one.
module canonical_prefix_compare_unit #(
    parameter int MAX_LEN = cpc_pkg::CPC_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        s_tuser,    // [0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [2:0] order_code, [3] is_match, [7:4] zero
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpc_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    // config registers
    logic fold_case_reg;
    logic dict_order_reg;

    // front stage bookkeeping
    logic [LEN_W-1:0] load_count_reg;
    logic [LEN_W-1:0] key_length_reg;
    logic [LEN_W-1:0] entry_pos_reg;   // kept entry bytes so far (speculative position)

    logic       accept;
    logic       cfg_wr;
    canon_t     canon;
    item_t      item;
    logic       key_wr;
    logic       key_rd;
    logic [7:0] key_byte;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_case_reg  <= 1'b1;
            dict_order_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_FOLD_CASE:  fold_case_reg  <= pwdata[0];
                CFG_DICT_ORDER: dict_order_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_FOLD_CASE:  prdata = {31'd0, fold_case_reg};
            CFG_DICT_ORDER: prdata = {31'd0, dict_order_reg};
            default:        prdata = '0;
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign canon  = cpc_canon(s_tdata, fold_case_reg, dict_order_reg);

    // key byte goes straight into the RAM; entry byte reads its key
    // position, assuming all earlier kept bytes matched. Once the order is
    // settled the later reads don't matter.
    assign key_wr = accept && !s_tuser && (s_tdata != 8'd0) && canon.keep
                    && (load_count_reg < LEN_MAX);
    assign key_rd = accept && s_tuser && (s_tdata != 8'd0) && canon.keep
                    && (entry_pos_reg < LEN_MAX);

    always_comb begin
        item.ch          = canon.value;
        item.len_reached = (entry_pos_reg >= key_length_reg);
        if (!s_tuser) begin
            item.kind = KIND_NONE;
        end else if (s_tdata == 8'd0) begin
            item.kind = KIND_END;
        end else if (key_rd) begin
            item.kind = KIND_CMP;
        end else begin
            item.kind = KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            key_length_reg <= '0;
            entry_pos_reg  <= '0;
        end else if (accept) begin
            if (!s_tuser) begin
                if (s_tdata == 8'd0) begin
                    key_length_reg <= load_count_reg;
                    load_count_reg <= '0;
                end else if (key_wr) begin
                    load_count_reg <= load_count_reg + LEN_W'(1);
                end
            end else begin
                if (s_tdata == 8'd0) begin
                    entry_pos_reg <= '0;
                end else if (key_rd) begin
                    entry_pos_reg <= entry_pos_reg + LEN_W'(1);
                end
            end
        end
    end

    cpc_key_mem #(
        .DEPTH (MAX_LEN)
    ) u_key_mem (
        .aclk    (aclk),
        .wr_en   (key_wr),
        .wr_addr (load_count_reg[ADDR_W-1:0]),
        .wr_data (canon.value),
        .rd_en   (key_rd),
        .rd_addr (entry_pos_reg[ADDR_W-1:0]),
        .rd_data (key_byte)
    );

    cpc_order u_order (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_load  (accept),
        .in_item  (item),
        .in_ready (s_tready),
        .key_byte (key_byte),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // counters never run past the key RAM
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_count_reg <= LEN_MAX) && (entry_pos_reg <= LEN_MAX) && (key_length_reg <= LEN_MAX))
        else $error("key or entry position past MAX_LEN");

    // match flag agrees with the order code
    a_match_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == ((m_tdata[2:0] == ORD_PREFIX) || (m_tdata[2:0] == ORD_EQUAL))))
        else $error("is_match inconsistent with order_code");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= ORD_AFTER) && (m_tdata[7:4] == 4'd0))
        else $error("order_code out of range");

    // input only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");
endmodule

[design/cpc_key_mem.sv]
module cpc_key_mem #(
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[design/cpc_order.sv]
module cpc_order (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_load,
    input  cpc_pkg::item_t  in_item,
    output logic            in_ready,
    input  logic [7:0]      key_byte,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata
);
    import cpc_pkg::*;

    item_t      s2_reg;
    logic       decided_reg;
    ord_t       dcode_reg;
    logic       out_valid_reg;
    ord_t       out_code_reg;
    logic       out_match_reg;

    logic       out_free;
    logic       s2_go;
    ord_t       end_code;

    assign out_free = !out_valid_reg || m_tready;
    assign s2_go    = (s2_reg.kind != KIND_END) || out_free;
    assign in_ready = s2_go;

    always_comb begin
        if (decided_reg) begin
            end_code = dcode_reg;
        end else if (s2_reg.len_reached) begin
            end_code = ORD_EQUAL;
        end else begin
            end_code = ORD_SHORT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg        <= '0;
            decided_reg   <= 1'b0;
            dcode_reg     <= ORD_BEFORE;
            out_valid_reg <= 1'b0;
        end else begin
            if (s2_go && (s2_reg.kind == KIND_END)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (s2_go) begin
                unique case (s2_reg.kind)
                    KIND_CMP: begin
                        if (!decided_reg) begin
                            if (s2_reg.len_reached) begin
                                decided_reg <= 1'b1;
                                dcode_reg   <= ORD_PREFIX;
                            end else if (key_byte != s2_reg.ch) begin
                                decided_reg <= 1'b1;
                                dcode_reg   <= ($signed(key_byte) < $signed(s2_reg.ch))
                                               ? ORD_BEFORE : ORD_AFTER;
                            end
                        end
                    end
                    KIND_END: begin
                        out_code_reg  <= end_code;
                        out_match_reg <= (end_code == ORD_PREFIX) || (end_code == ORD_EQUAL);
                        decided_reg   <= 1'b0;
                        dcode_reg     <= ORD_BEFORE;
                    end
                    default: begin
                    end
                endcase
                if (in_load) begin
                    s2_reg <= in_item;
                end else begin
                    s2_reg.kind <= KIND_NONE;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_match_reg, out_code_reg};
endmodule

[verif/cpc_checker.sv]
package cpc_tb_pkg;

    localparam logic REQ_KEY   = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    typedef struct packed {
        cpc_pkg::ord_t code;
        logic          is_match;
    } verdict_t;

endpackage

module cpc_checker
    import cpc_pkg::*;
    import cpc_tb_pkg::*;
#(
    parameter int MAX_LEN = CPC_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        s_tuser,    // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [2:0] order_code, [3] is_match, [7:4] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  key_bytes [MAX_LEN];
    int unsigned key_len;
    int unsigned load_cnt;
    int unsigned match_pos;
    logic        settled;
    ord_t        settled_code;
    logic        fold_en;
    logic        dict_en;
    verdict_t    verdict_q [$];

    // bit 8 = byte kept, [7:0] = canonical value
    function automatic logic [8:0] canonize(logic [7:0] c);
        logic hi;
        logic lo;
        logic dig;
        logic blank;
        hi    = (c >= 8'h41) && (c <= 8'h5A);
        lo    = (c >= 8'h61) && (c <= 8'h7A);
        dig   = (c >= 8'h30) && (c <= 8'h39);
        blank = (c == 8'h20) || (c == 8'h09);
        if (dict_en && !(hi || lo || dig || blank))
            return 9'h000;
        return {1'b1, (fold_en && hi) ? (c | 8'h20) : c};
    endfunction

    task automatic take_byte(logic kind, logic [7:0] c);
        logic [8:0] cv;
        verdict_t   v;
        cv = canonize(c);
        if (kind == REQ_KEY) begin
            if (c == 8'h00) begin
                key_len  = load_cnt;
                load_cnt = 0;
            end else if (load_cnt < MAX_LEN && cv[8]) begin
                key_bytes[load_cnt] = cv[7:0];
                load_cnt++;
            end
        end else if (c == 8'h00) begin
            if (settled)
                v.code = settled_code;
            else if (match_pos >= key_len)
                v.code = ORD_EQUAL;
            else
                v.code = ORD_SHORT;
            v.is_match = (v.code == ORD_PREFIX) || (v.code == ORD_EQUAL);
            verdict_q.push_back(v);
            match_pos    = 0;
            settled      = 1'b0;
            settled_code = ORD_BEFORE;
        end else if (!settled && match_pos < MAX_LEN && cv[8]) begin
            if (match_pos >= key_len) begin
                settled      = 1'b1;
                settled_code = ORD_PREFIX;
            end else if (key_bytes[match_pos] == cv[7:0]) begin
                match_pos++;
            end else begin
                settled = 1'b1;
                if ($signed(key_bytes[match_pos]) < $signed(cv[7:0]))
                    settled_code = ORD_BEFORE;
                else
                    settled_code = ORD_AFTER;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        verdict_t want;
        if (!aresetn) begin
            key_len      = 0;
            load_cnt     = 0;
            match_pos    = 0;
            settled      = 1'b0;
            settled_code = ORD_BEFORE;
            fold_en      = 1'b1;
            dict_en      = 1'b1;
            fail_count   = 0;
            verdict_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_byte(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t ns: unexpected result, got tdata %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[2:0] != want.code) begin
                        $display("%0t ns: order_code expected %0d, got %0d",
                                 $time, want.code, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[3] != want.is_match) begin
                        $display("%0t ns: is_match expected %0d, got %0d",
                                 $time, want.is_match, m_tdata[3]);
                        fail_count++;
                    end
                    if (m_tdata[7:4] != 4'h0) begin
                        $display("%0t ns: tdata pad expected 0, got %h",
                                 $time, m_tdata[7:4]);
                        fail_count++;
                    end
                end
            end
            // register writes take effect after this edge's byte
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == CFG_FOLD_CASE)
                    fold_en = pwdata[0];
                else
                    dict_en = pwdata[0];
            end
        end
        pending = verdict_q.size();
    end

endmodule

[verif/canonical_prefix_compare_unit_tb.sv]
module canonical_prefix_compare_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;
    import cpc_tb_pkg::*;

    // watchdog limit, with a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT  = 400000;
    // extra settling after the last predicted result has come out
    localparam int DRAIN_CYCLES = 16;
    // long receiver hold-off to back the block up into its input
    localparam int HOLD_CYCLES  = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] ch
    logic        s_tuser;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [2:0] order_code, [3] is_match, [7:4] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          sent_cnt;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    canonical_prefix_compare_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Scoreboard: tracks both streams and the APB port, predicts every result.
    cpc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a missing result ends up here.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("canonical_prefix_compare_unit regression: fail");
        $finish;
    end

    // Result side. Random back-pressure at the current rate; a hold-off
    // request parks m_tready low for HOLD_CYCLES, counted here, so the
    // sender keeps pushing until the block runs out of room.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(negedge aclk);
                hold_off = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // One request on the input stream. Called at a falling edge; returns at
    // the falling edge after the accepting rising edge.
    task automatic send(logic kind, logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_cnt++;
        @(negedge aclk);
    endtask

    // Whole key or entry from text, closed by its zero byte.
    task automatic send_word(logic kind, string txt);
        for (int i = 0; i < txt.len(); i++)
            send(kind, txt[i]);
        send(kind, 8'h00);
    endtask

    // Wait until every predicted result has come out and the pipeline has
    // settled (bytes that produce no result may still be in flight).
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup cycle, access cycle. Only issued with the block idle.
    task automatic cfg_write(logic idx, logic val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly letters, digits and blanks, with a fair share of arbitrary
    // nonzero bytes (punctuation, control, 128..255).
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0, 1:    return 8'(8'h61 + $urandom_range(0, 25));
            2:       return 8'(8'h41 + $urandom_range(0, 25));
            3:       return 8'(8'h30 + $urandom_range(0, 9));
            4:       return $urandom_range(0, 1) ? 8'h20 : 8'h09;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // A key followed by a few entries derived from it: same text with case
    // flips, cut short or run long, a byte swapped, punctuation slipped in,
    // now and then a key byte landing mid-entry. One session in ten is raw
    // noise of both request kinds, zero bytes included.
    task automatic word_session();
        logic [7:0] word [$];
        logic [7:0] c;
        int         len;
        int         cut;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                send(1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(0, 7) == 0)
            cfg_write(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
            word.push_back(rand_byte());
        foreach (word[i])
            send(REQ_KEY, word[i]);
        // once in a while the key stays open and runs into the next one
        if ($urandom_range(0, 19) != 0)
            send(REQ_KEY, 8'h00);
        repeat ($urandom_range(1, 6)) begin
            cut = $urandom_range(0, len + 2);
            for (int pos = 0; pos < cut; pos++) begin
                c = (pos < len) ? word[pos] : rand_byte();
                if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1))
                    c = c ^ 8'h20;
                if ($urandom_range(0, 11) == 0)
                    c = rand_byte();
                if ($urandom_range(0, 11) == 0)
                    send(REQ_ENTRY, 8'(8'h21 + $urandom_range(0, 14)));
                if ($urandom_range(0, 39) == 0)
                    send(REQ_KEY, rand_byte());
                send(REQ_ENTRY, c);
            end
            send(REQ_ENTRY, 8'h00);
        end
    endtask

    initial begin : stimulus
        logic [7:0] long_key [$];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = REQ_KEY;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        hold_off      = 1'b0;
        sent_cnt      = 0;
        send_idle_pct = 7;
        recv_idle_pct = 45;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed ---
        // No key finished yet: empty entry is equal, any byte makes it a prefix.
        send_word(REQ_ENTRY, "");
        send_word(REQ_ENTRY, "q");

        // Reset config (fold, dict on): key "Ab" stores as "ab".
        send_word(REQ_KEY, "Ab");
        send_word(REQ_ENTRY, "AB");     // equal
        send_word(REQ_ENTRY, "a");      // entry shorter than key
        send_word(REQ_ENTRY, "abc");    // key proper prefix
        send_word(REQ_ENTRY, "a-b");    // '-' dropped -> equal
        send_word(REQ_ENTRY, "acz!z");  // key before; bytes past the decision ignored
        send_word(REQ_ENTRY, "aa");     // key after

        // Fold and dict both off: high bytes kept and compared as negative.
        cfg_write(CFG_FOLD_CASE, 1'b0);
        cfg_write(CFG_DICT_ORDER, 1'b0);
        send(REQ_KEY, 8'h80);
        send(REQ_KEY, 8'hFF);
        send(REQ_KEY, 8'h41);
        send(REQ_KEY, 8'h00);
        send(REQ_ENTRY, 8'h80);
        send(REQ_ENTRY, 8'hFF);
        send(REQ_ENTRY, 8'h61);         // no folding: 'A' < 'a'
        send(REQ_ENTRY, 8'h00);
        send(REQ_ENTRY, 8'h7F);         // 0x80 is -128, below 0x7F
        send(REQ_ENTRY, 8'h00);

        // Setting changed halfway through an entry.
        cfg_write(CFG_FOLD_CASE, 1'b1);
        cfg_write(CFG_DICT_ORDER, 1'b1);
        send_word(REQ_KEY, "abc");
        send(REQ_ENTRY, "a");
        cfg_write(CFG_DICT_ORDER, 1'b0);
        send(REQ_ENTRY, "-");           // now kept, compared against 'b'
        send(REQ_ENTRY, 8'h00);
        cfg_write(CFG_DICT_ORDER, 1'b1);

        // Key reloaded while an entry is open: store overwritten in place,
        // old length still in force.
        send(REQ_ENTRY, "a");
        send(REQ_KEY, "x");
        send(REQ_KEY, "b");
        send(REQ_ENTRY, "b");
        send(REQ_ENTRY, "c");
        send(REQ_ENTRY, 8'h00);
        send(REQ_KEY, 8'h00);

        // Key longer than the store: only the first 256 kept bytes count.
        for (int i = 0; i < CPC_MAX_LEN + 8; i++)
            long_key.push_back(8'(8'h61 + $urandom_range(0, 25)));
        foreach (long_key[i])
            send(REQ_KEY, long_key[i]);
        send(REQ_KEY, 8'h00);
        foreach (long_key[i])
            send(REQ_ENTRY, long_key[i]);   // matches past the store end: equal
        send(REQ_ENTRY, 8'h00);
        for (int i = 0; i < CPC_MAX_LEN; i++)
            send(REQ_ENTRY, long_key[i]);
        send(REQ_ENTRY, "Z");               // beyond the limit, ignored
        send(REQ_ENTRY, 8'h00);
        for (int i = 0; i < 20; i++)
            send(REQ_ENTRY, long_key[i]);
        send(REQ_ENTRY, 8'h00);

        // --- random: sender lightly idle, receiver heavily stalled ---
        cfg_write(CFG_FOLD_CASE, 1'b0);
        cfg_write(CFG_DICT_ORDER, 1'b1);
        sent_cnt = 0;
        while (sent_cnt < 220)
            word_session();

        // --- random: roles swapped ---
        send_idle_pct = 45;
        recv_idle_pct = 7;
        cfg_write(CFG_FOLD_CASE, 1'b1);
        cfg_write(CFG_DICT_ORDER, 1'b0);
        while (sent_cnt < 440)
            word_session();

        // --- random: full rate both sides, with one long receiver hold-off ---
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(CFG_FOLD_CASE, 1'b0);
        cfg_write(CFG_DICT_ORDER, 1'b0);
        hold_off = 1'b1;
        while (sent_cnt < 660)
            word_session();

        drain();
        if (fail_count == 0)
            $display("canonical_prefix_compare_unit regression: pass");
        else
            $display("canonical_prefix_compare_unit regression: fail");
        $finish;
    end

endmodule
